// File: hdl/ata_pkg.sv
// ata_pkg: shared widths, item and status types, and the CORDIC arctangent table
// for the accelerometer tilt angle block. No dependencies.
package ata_pkg;

  localparam int DataW       = 16;
  localparam int OperW       = 18;
  localparam int SumW        = 32;
  localparam int RootW       = 16;
  localparam int SqrtStages  = 16;
  localparam int CordicSteps = 20;
  localparam int CordicW     = 36;
  localparam int AngW        = 25;
  localparam int AngleW      = 16;
  localparam int PitchW      = 15;
  localparam int FracShift   = 16;
  localparam int QueueDepth  = 2;

  localparam logic signed [AngW-1:0]   Ang90      = 25'sd2304000;
  localparam logic signed [AngW-1:0]   AngRound   = 25'sd128;
  localparam logic signed [AngW-1:0]   AngLimit   = 25'sd18000;
  localparam logic signed [AngleW-1:0] PitchLimit = 16'sd9000;
  localparam logic signed [AngleW:0]   AxisOffset = 17'sd18000;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
  } sample_t;

  typedef struct packed {
    sample_t        smp;
    logic [SumW-1:0] sumsq;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // atan(2^-i) in 1/25600 degree
  function automatic logic signed [AngW-1:0] atan_step(input int unsigned i);
    logic signed [AngW-1:0] v;
    unique case (i)
      0:       v = 25'sd1152000;
      1:       v = 25'sd680065;
      2:       v = 25'sd359328;
      3:       v = 25'sd182400;
      4:       v = 25'sd91554;
      5:       v = 25'sd45822;
      6:       v = 25'sd22916;
      7:       v = 25'sd11459;
      8:       v = 25'sd5730;
      9:       v = 25'sd2865;
      10:      v = 25'sd1432;
      11:      v = 25'sd716;
      12:      v = 25'sd358;
      13:      v = 25'sd179;
      14:      v = 25'sd90;
      15:      v = 25'sd45;
      16:      v = 25'sd22;
      17:      v = 25'sd11;
      18:      v = 25'sd6;
      19:      v = 25'sd3;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/ata_queue.sv
// ata_queue: small FIFO between the front and the back of the pipeline.
// Depends on ata_pkg (item_t, qstat_t).
module ata_queue #(
  parameter int Depth = ata_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ata_pkg::item_t   item_i,
  input  logic             pop_i,
  output ata_pkg::item_t   item_o,
  output ata_pkg::qstat_t  stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ata_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ata_front.sv
// ata_front: accepts samples and prepares them for the back end (sum of squares).
// Depends on ata_pkg.
module ata_front (
  input  logic                           valid_i,
  input  logic signed [ata_pkg::DataW-1:0] accel_x_i,
  input  logic signed [ata_pkg::DataW-1:0] accel_y_i,
  input  logic signed [ata_pkg::DataW-1:0] accel_z_i,
  input  ata_pkg::qstat_t                stat_i,
  output logic                           stall_o,
  output logic                           push_o,
  output ata_pkg::item_t                 item_o
);

  logic signed [ata_pkg::SumW-1:0] yy, zz;

  assign yy = accel_y_i * accel_y_i;
  assign zz = accel_z_i * accel_z_i;

  assign stall_o      = stat_i.full;
  assign push_o       = valid_i && !stat_i.full;
  assign item_o.smp.x = accel_x_i;
  assign item_o.smp.y = accel_y_i;
  assign item_o.smp.z = accel_z_i;
  assign item_o.sumsq = $unsigned(yy) + $unsigned(zz);

endmodule

// File: hdl/ata_sqrt.sv
// ata_sqrt: pipelined integer square root, one result bit per stage.
// Depends on ata_pkg.
module ata_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ata_pkg::SumW-1:0]      v_i,
  output logic [ata_pkg::RootW-1:0]     root_o
);

  localparam int N = ata_pkg::SqrtStages;
  localparam int W = ata_pkg::SumW;

  logic [W-1:0] v_q   [N];
  logic [W-1:0] res_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] Bit = W'(1) << (W - 2 - 2 * k);
    logic [W-1:0] v_cur, res_cur, trial;
    if (k == 0) begin : g_first
      assign v_cur   = v_i;
      assign res_cur = '0;
    end else begin : g_next
      assign v_cur   = v_q[k-1];
      assign res_cur = res_q[k-1];
    end
    assign trial = res_cur + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_cur >= trial) begin
          v_q[k]   <= v_cur - trial;
          res_q[k] <= (res_cur >> 1) + Bit;
        end else begin
          v_q[k]   <= v_cur;
          res_q[k] <= res_cur >> 1;
        end
      end
    end
  end

  assign root_o = res_q[N-1][ata_pkg::RootW-1:0];

endmodule

// File: hdl/ata_cordic.sv
// ata_cordic: pipelined CORDIC vectoring atan2, result in 0.01 degree, saturated.
// Depends on ata_pkg (widths, atan_step table).
module ata_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [ata_pkg::OperW-1:0]  a_i,
  input  logic signed [ata_pkg::OperW-1:0]  b_i,
  output logic signed [ata_pkg::AngleW-1:0] angle_o
);

  localparam int N  = ata_pkg::CordicSteps;
  localparam int W  = ata_pkg::CordicW;
  localparam int AW = ata_pkg::AngW;

  logic signed [W-1:0]  x_q   [N+1];
  logic signed [W-1:0]  y_q   [N+1];
  logic signed [AW-1:0] ang_q [N+1];
  logic                 zero_q [N+1];

  logic signed [ata_pkg::OperW-1:0] x0, y0;
  logic signed [AW-1:0]             ang0;

  // quarter turn so the vector starts in the right half plane
  always_comb begin
    if (b_i < 0) begin
      if (a_i >= 0) begin
        x0 = a_i;   y0 = -b_i; ang0 = ata_pkg::Ang90;
      end else begin
        x0 = -a_i;  y0 = b_i;  ang0 = -ata_pkg::Ang90;
      end
    end else begin
      x0 = b_i; y0 = a_i; ang0 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= W'(x0) <<< ata_pkg::FracShift;
      y_q[0]    <= W'(y0) <<< ata_pkg::FracShift;
      ang_q[0]  <= ang0;
      zero_q[0] <= (a_i == '0) && (b_i == '0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [W-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1]   <= x_q[i] + dx;
          y_q[i+1]   <= y_q[i] - dy;
          ang_q[i+1] <= ang_q[i] + ata_pkg::atan_step(i);
        end else begin
          x_q[i+1]   <= x_q[i] - dx;
          y_q[i+1]   <= y_q[i] + dy;
          ang_q[i+1] <= ang_q[i] - ata_pkg::atan_step(i);
        end
      end
    end
  end

  logic signed [AW-1:0] rnd, sat;

  always_comb begin
    rnd = (ang_q[N] + ata_pkg::AngRound) >>> 8;
    if (rnd > ata_pkg::AngLimit) begin
      sat = ata_pkg::AngLimit;
    end else if (rnd < -ata_pkg::AngLimit) begin
      sat = -ata_pkg::AngLimit;
    end else begin
      sat = rnd;
    end
  end

  assign angle_o = zero_q[N] ? '0 : sat[ata_pkg::AngleW-1:0];

endmodule

// File: hdl/accel_tilt_angles.sv
// accel_tilt_angles: top level; front, queue, square root and five CORDIC lanes.
// Depends on ata_pkg, ata_front, ata_queue, ata_sqrt, ata_cordic.
//
//  channel  dir  handshake          payload
//  sample   in   valid_i / stall_o  accel_x_i, accel_y_i, accel_z_i
//  angles   out  valid_o / stall_i  x_axis, y_axis, heading, roll, pitch angles
//
// One item per cycle sustained while no output stall freezes the pipeline; stages are
// 16 square-root stages, 21 CORDIC stages and the output register.
// A stall while valid_o is high freezes the whole back pipeline; the queue keeps
// taking items until it holds QueueDepth of them.
// Reset clears the queue, valid line and output valid only.
module accel_tilt_angles #(
  parameter int QueueDepth = ata_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic signed [ata_pkg::DataW-1:0]  accel_x_i,
  input  logic signed [ata_pkg::DataW-1:0]  accel_y_i,
  input  logic signed [ata_pkg::DataW-1:0]  accel_z_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic [ata_pkg::AngleW-1:0]        x_axis_angle_o,
  output logic [ata_pkg::AngleW-1:0]        y_axis_angle_o,
  output logic [ata_pkg::AngleW-1:0]        heading_angle_o,
  output logic signed [ata_pkg::AngleW-1:0] roll_angle_o,
  output logic signed [ata_pkg::PitchW-1:0] pitch_angle_o
);

  localparam int Lat = ata_pkg::SqrtStages + ata_pkg::CordicSteps + 1;
  localparam int OW  = ata_pkg::OperW;

  ata_pkg::item_t  push_item, head_item;
  ata_pkg::qstat_t qstat;
  logic            push, pop, en;

  logic valid_q;
  logic vld_q [Lat];

  assign en      = !(valid_q && stall_i);
  assign pop     = en && !qstat.empty;
  assign valid_o = valid_q;

  ata_front u_front (
    .valid_i   (valid_i),
    .accel_x_i (accel_x_i),
    .accel_y_i (accel_y_i),
    .accel_z_i (accel_z_i),
    .stat_i    (qstat),
    .stall_o   (stall_o),
    .push_o    (push),
    .item_o    (push_item)
  );

  ata_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (qstat)
  );

  logic [ata_pkg::RootW-1:0] root;

  ata_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (head_item.sumsq),
    .root_o (root)
  );

  ata_pkg::sample_t dly_q [ata_pkg::SqrtStages];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= head_item.smp;
      for (int k = 1; k < ata_pkg::SqrtStages; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  logic signed [OW-1:0] sx, sy, sz, nx, ny, nz, sr;
  assign sx = OW'(dly_q[ata_pkg::SqrtStages-1].x);
  assign sy = OW'(dly_q[ata_pkg::SqrtStages-1].y);
  assign sz = OW'(dly_q[ata_pkg::SqrtStages-1].z);
  assign nx = -sx;
  assign ny = -sy;
  assign nz = -sz;
  assign sr = $signed({{(OW - ata_pkg::RootW){1'b0}}, root});

  logic signed [ata_pkg::AngleW-1:0] ang_xa, ang_ya, ang_hd, ang_rl, ang_pt;

  ata_cordic u_xaxis (.clk_i(clk_i), .en_i(en), .a_i(nx), .b_i(nz), .angle_o(ang_xa));
  ata_cordic u_yaxis (.clk_i(clk_i), .en_i(en), .a_i(ny), .b_i(nz), .angle_o(ang_ya));
  ata_cordic u_head  (.clk_i(clk_i), .en_i(en), .a_i(sx), .b_i(sy), .angle_o(ang_hd));
  ata_cordic u_roll  (.clk_i(clk_i), .en_i(en), .a_i(sy), .b_i(sz), .angle_o(ang_rl));
  ata_cordic u_pitch (.clk_i(clk_i), .en_i(en), .a_i(nx), .b_i(sr), .angle_o(ang_pt));

  logic signed [ata_pkg::AngleW:0]   xa_sum, ya_sum, hd_sum;
  logic signed [ata_pkg::AngleW-1:0] pt_sat;

  assign xa_sum = $signed({ang_xa[ata_pkg::AngleW-1], ang_xa}) + ata_pkg::AxisOffset;
  assign ya_sum = $signed({ang_ya[ata_pkg::AngleW-1], ang_ya}) + ata_pkg::AxisOffset;
  assign hd_sum = $signed({ang_hd[ata_pkg::AngleW-1], ang_hd}) + ata_pkg::AxisOffset;

  always_comb begin
    if (ang_pt > ata_pkg::PitchLimit) begin
      pt_sat = ata_pkg::PitchLimit;
    end else if (ang_pt < -ata_pkg::PitchLimit) begin
      pt_sat = -ata_pkg::PitchLimit;
    end else begin
      pt_sat = ang_pt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int k = 0; k < Lat; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= pop;
      for (int k = 1; k < Lat; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      valid_q <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_axis_angle_o  <= xa_sum[ata_pkg::AngleW-1:0];
      y_axis_angle_o  <= ya_sum[ata_pkg::AngleW-1:0];
      heading_angle_o <= hd_sum[ata_pkg::AngleW-1:0];
      roll_angle_o    <= ang_rl;
      pitch_angle_o   <= pt_sat[ata_pkg::PitchW-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full) else $error("push into full queue");

  a_pipe_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[Lat-1]) |=> valid_q) else $error("item lost at output register");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($signed(pitch_angle_o) <= 15'sd9000 && $signed(pitch_angle_o) >= -15'sd9000))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (roll_angle_o <= 16'sd18000 && roll_angle_o >= -16'sd18000))
    else $error("roll out of range");
`endif

endmodule

// File: tb/sv/tb_accel_tilt_angles_chk.sv
// Checker for accel_tilt_angles: watches the sample and angle channels, predicts
// the five angles of each accepted sample and compares them in order. Uses ata_pkg.
`timescale 1ns / 100ps
module tb_accel_tilt_angles_chk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic                              stall_o,
  input  logic signed [ata_pkg::DataW-1:0]  accel_x_i,
  input  logic signed [ata_pkg::DataW-1:0]  accel_y_i,
  input  logic signed [ata_pkg::DataW-1:0]  accel_z_i,
  input  logic                              valid_o,
  input  logic                              stall_i,
  input  logic [ata_pkg::AngleW-1:0]        x_axis_angle_o,
  input  logic [ata_pkg::AngleW-1:0]        y_axis_angle_o,
  input  logic [ata_pkg::AngleW-1:0]        heading_angle_o,
  input  logic signed [ata_pkg::AngleW-1:0] roll_angle_o,
  input  logic signed [ata_pkg::PitchW-1:0] pitch_angle_o,
  output int                                fail_cnt,
  output int                                pending,
  output int                                angles_seen
);
  typedef struct packed {
    logic [15:0]        xa;
    logic [15:0]        ya;
    logic [15:0]        hd;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
  } angles_t;

  angles_t angles_q[$];

  localparam longint AtanTab[20] = '{1152000, 680065, 359328, 182400, 91554, 45822,
    22916, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};

  function automatic longint cordic_atan2(longint a, longint b);
    longint cx, cy, ang, dx, dy, r;
    if (a == 0 && b == 0) return 0;
    if (b < 0) begin
      if (a >= 0) begin
        cx = a; cy = -b; ang = 2304000;
      end else begin
        cx = -a; cy = b; ang = -2304000;
      end
    end else begin
      cx = b; cy = a; ang = 0;
    end
    cx = cx * 65536;
    cy = cy * 65536;
    for (int i = 0; i < 20; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; ang += AtanTab[i];
      end else begin
        cx -= dx; cy += dy; ang -= AtanTab[i];
      end
    end
    r = (ang + 128) >>> 8;
    if (r > 18000) r = 18000;
    if (r < -18000) r = -18000;
    return r;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r += 64'sd1 << b;
    return r;
  endfunction

  function automatic angles_t tilt_angles(longint ax, longint ay, longint az);
    angles_t e;
    longint p;
    e.xa = 16'(cordic_atan2(-ax, -az) + 18000);
    e.ya = 16'(cordic_atan2(-ay, -az) + 18000);
    e.hd = 16'(cordic_atan2(ax, ay) + 18000);
    e.roll = 16'(cordic_atan2(ay, az));
    p = cordic_atan2(-ax, int_sqrt(ay * ay + az * az));
    if (p > 9000) p = 9000;
    if (p < -9000) p = -9000;
    e.pitch = 15'(p);
    return e;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  initial begin
    fail_cnt = 0;
    angles_seen = 0;
  end
  assign pending = angles_q.size();

  always @(posedge clk_i) begin
    angles_t e;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        angles_seen++;
        if (angles_q.size() == 0) begin
          $display("MISMATCH unexpected angle item at %0t", $realtime);
          fail_cnt++;
        end else begin
          e = angles_q.pop_front();
          if (x_axis_angle_o !== e.xa) report("x_axis", x_axis_angle_o, e.xa);
          if (y_axis_angle_o !== e.ya) report("y_axis", y_axis_angle_o, e.ya);
          if (heading_angle_o !== e.hd) report("heading", heading_angle_o, e.hd);
          if (roll_angle_o !== e.roll) report("roll", roll_angle_o, e.roll);
          if (pitch_angle_o !== e.pitch) report("pitch", pitch_angle_o, e.pitch);
        end
      end
      if (valid_i && !stall_o)
        angles_q.push_back(tilt_angles(accel_x_i, accel_y_i, accel_z_i));
    end
  end
endmodule

// File: tb/sv/tb_accel_tilt_angles.sv
// Testbench top for accel_tilt_angles: drives directed and random samples with
// random idling on both sides; checking is done in tb_accel_tilt_angles_chk.
`timescale 1ns / 100ps
module tb_accel_tilt_angles;
  logic clk_i = 1'b0, rst_ni = 1'b0, valid_i = 1'b0, stall_i = 1'b0;
  logic stall_o, valid_o;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic [15:0] x_axis_angle_o, y_axis_angle_o, heading_angle_o;
  logic signed [15:0] roll_angle_o;
  logic signed [14:0] pitch_angle_o;
  int fail_cnt, pending, angles_seen, send_idle, recv_idle, sent;

  always #5 clk_i = ~clk_i;

  accel_tilt_angles dut (.*);
  tb_accel_tilt_angles_chk chk (.*);

  always @(posedge clk_i) stall_i <= ($urandom_range(99) < recv_idle);

  function automatic logic [15:0] pick_val();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(8)) - 4);
      3: return 16'h8000 + 16'($urandom_range(4));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
    while ($urandom_range(99) < send_idle) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    accel_x_i <= sx;
    accel_y_i <= sy;
    accel_z_i <= sz;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sent++;
  endtask

  initial begin
    logic [15:0] ext[6];
    ext = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h4000};
    sent = 0;
    send_idle = 38;
    recv_idle = 87;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // zero pairs, negative-axis zeros, full-scale corners
    for (int i = 0; i < 6; i++)
      send(ext[i], ext[(i + 2) % 6], ext[(i + 4) % 6]);
    send(16'h0000, 16'h0000, 16'h0000);
    send(16'h0000, 16'hffff, 16'h8000);
    send(16'h0000, 16'h0000, 16'h8000);
    send(16'h8000, 16'h0000, 16'h0000);
    send(16'h7fff, 16'h0000, 16'h0000);
    send(16'h8000, 16'h8000, 16'h8000);
    send(16'h7fff, 16'h7fff, 16'h7fff);
    send(16'hffff, 16'hffff, 16'hffff);
    send(16'h0001, 16'h0000, 16'h0000);
    send(16'h0000, 16'h0001, 16'hffff);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 38 : (ph == 1) ? 87 : 0;
      recv_idle = (ph == 0) ? 87 : (ph == 1) ? 38 : 0;
      for (int n = 0; n < 510; n++) send(pick_val(), pick_val(), pick_val());
    end
    valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d samples, checked %0d angle items, extremes and zero", sent,
             angles_seen);
    $display("cases included, under three idling mixes.");
    if (fail_cnt == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
